/* design/small_matrix_inverse_core_macros.svh */
// Assertion macros used by the port-level checker of the matrix inverse core.
`ifndef SMALL_MATRIX_INVERSE_CORE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_CORE_MACROS_SVH
`define SMI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SMI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* design/smi_pkg.sv */
// Package with widths, product tables and types of the matrix inverse core.
`default_nettype none
package smi_pkg;
    localparam int ENTRY_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 48;
    localparam int DETO_W = 49;
    localparam int PW   = 2 * ENTRY_BITS;
    localparam int AW   = PW + 1;
    localparam int DTW  = 3 * ENTRY_BITS + 1;
    localparam int DW   = DTW - 1;
    localparam int NW   = AW - 1 + FRAC_BITS;

    typedef logic signed [ENTRY_BITS-1:0] entry_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [AW-1:0]         adj_t;
    typedef logic signed [DTW-1:0]        det_t;

    typedef int unsigned idx_tab_t [18];
    localparam idx_tab_t PROD_A = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam idx_tab_t PROD_B = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    localparam logic [1:0] DIM_ONE   = 2'd1;
    localparam logic [1:0] DIM_TWO   = 2'd2;
    localparam logic [1:0] DIM_THREE = 2'd3;
endpackage
`default_nettype wire

/* design/small_matrix_inverse_core.sv */
// Top level of the pipelined small matrix determinant and inverse core.
// Pipeline: an input register, four arithmetic stages after it, the divider input stage, one
// restoring divider stage per quotient bit (48) and one output stage.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Reset: synchronous active-low aresetn clears all valid bits; data registers are not reset.
`default_nettype none
module small_matrix_inverse_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_dimension,
    input  wire logic signed [15:0] s_a_r0c0,
    input  wire logic signed [15:0] s_a_r0c1,
    input  wire logic signed [15:0] s_a_r0c2,
    input  wire logic signed [15:0] s_a_r1c0,
    input  wire logic signed [15:0] s_a_r1c1,
    input  wire logic signed [15:0] s_a_r1c2,
    input  wire logic signed [15:0] s_a_r2c0,
    input  wire logic signed [15:0] s_a_r2c1,
    input  wire logic signed [15:0] s_a_r2c2,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [47:0] m_inv_r0c0,
    output logic signed [47:0] m_inv_r0c1,
    output logic signed [47:0] m_inv_r0c2,
    output logic signed [47:0] m_inv_r1c0,
    output logic signed [47:0] m_inv_r1c1,
    output logic signed [47:0] m_inv_r1c2,
    output logic signed [47:0] m_inv_r2c0,
    output logic signed [47:0] m_inv_r2c1,
    output logic signed [47:0] m_inv_r2c2,
    output logic signed [48:0] m_determinant,
    output logic             m_singular
);
    localparam int EB = smi_pkg::ENTRY_BITS;
    localparam int FB = smi_pkg::FRAC_BITS;
    localparam int NW = smi_pkg::NW;
    localparam int DW = smi_pkg::DW;
    localparam int AW = smi_pkg::AW;
    localparam int DTW = smi_pkg::DTW;

    logic en;
    logic [6:1] v_reg;
    logic [NW-1:0] dv_reg;
    logic out_v_reg;

    logic [1:0] dim1_reg, dim2_reg, dim3_reg, dim4_reg;
    smi_pkg::entry_t a1_reg [9];
    smi_pkg::entry_t a2_reg [3];
    smi_pkg::entry_t r0_2_reg [3];
    smi_pkg::entry_t a3_reg [3];
    smi_pkg::entry_t a00_4_reg;
    smi_pkg::prod_t  p2_reg [18];
    smi_pkg::adj_t   adj3_reg [9];
    smi_pkg::adj_t   cof3_reg;
    smi_pkg::adj_t   adj4_reg [9];
    smi_pkg::adj_t   cof4_reg;
    smi_pkg::det_t   dp4_reg [3];
    smi_pkg::adj_t   adj5_reg [9];
    smi_pkg::det_t   det5_reg;

    logic [DW-1:0]  rem_reg [NW+1][9];
    logic [NW-1:0]  nq_reg  [NW+1][9];
    logic [DW-1:0]  d_reg   [NW+1];
    logic [8:0]     neg_reg [NW+1];
    smi_pkg::det_t  det_reg [NW+1];

    logic signed [47:0] inv_reg [9];
    logic signed [48:0] deto_reg;
    logic sing_reg;

    logic [DW-1:0]  rem_next [NW+1][9];
    logic [NW-1:0]  nq_next  [NW+1][9];
    smi_pkg::adj_t  adj_next [9];
    smi_pkg::det_t  det_next;
    logic [DW-1:0]  mag_d;
    logic [AW-1:0]  mag_a [9];
    logic signed [47:0] inv_next [9];

    assign en      = !out_v_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_v_reg;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            adj_next[k] = smi_pkg::adj_t'(p2_reg[2*k]) - smi_pkg::adj_t'(p2_reg[2*k+1]);
        end
        if (dim2_reg == smi_pkg::DIM_ONE) begin
            for (int k = 0; k < 9; k++) adj_next[k] = '0;
            adj_next[0] = smi_pkg::adj_t'(1);
        end else if (dim2_reg == smi_pkg::DIM_TWO) begin
            for (int k = 0; k < 9; k++) adj_next[k] = '0;
            adj_next[0] = smi_pkg::adj_t'(a2_reg[0]);
            adj_next[1] = -smi_pkg::adj_t'(a2_reg[1]);
            adj_next[3] = -smi_pkg::adj_t'(a2_reg[2]);
            adj_next[4] = smi_pkg::adj_t'(r0_2_reg[0]);
        end else if (dim2_reg != smi_pkg::DIM_THREE) begin
            for (int k = 0; k < 9; k++) adj_next[k] = '0;
        end
    end

    always_comb begin
        logic signed [DTW+1:0] sum;
        sum = (DTW+2)'(dp4_reg[0]) + (DTW+2)'(dp4_reg[1]) + (DTW+2)'(dp4_reg[2]);
        unique case (dim4_reg)
            smi_pkg::DIM_ONE:   det_next = smi_pkg::det_t'(a00_4_reg);
            smi_pkg::DIM_TWO:   det_next = smi_pkg::det_t'(cof4_reg);
            smi_pkg::DIM_THREE: det_next = sum[DTW-1:0];
            default:            det_next = '0;
        endcase
    end

    always_comb begin
        logic [DTW-1:0] dabs;
        dabs  = det5_reg[DTW-1] ? DTW'(-det5_reg) : DTW'(det5_reg);
        mag_d = dabs[DW-1:0];
        for (int k = 0; k < 9; k++) begin
            mag_a[k] = adj5_reg[k][AW-1] ? AW'(-adj5_reg[k]) : AW'(adj5_reg[k]);
        end
    end

    always_comb begin
        for (int s = 0; s <= NW; s++) begin
            for (int k = 0; k < 9; k++) begin
                rem_next[s][k] = '0;
                nq_next[s][k]  = '0;
            end
        end
        for (int s = 1; s <= NW; s++) begin
            for (int k = 0; k < 9; k++) begin
                logic [DW:0] trial;
                logic [DW:0] diff;
                trial = {rem_reg[s-1][k], nq_reg[s-1][k][NW-1]};
                diff  = trial - {1'b0, d_reg[s-1]};
                if (!diff[DW]) begin
                    rem_next[s][k] = diff[DW-1:0];
                end else begin
                    rem_next[s][k] = trial[DW-1:0];
                end
                nq_next[s][k] = {nq_reg[s-1][k][NW-2:0], !diff[DW]};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            logic [NW-1:0] q;
            q = neg_reg[NW][k] ? NW'(-nq_reg[NW][k]) : nq_reg[NW][k];
            inv_next[k] = (det_reg[NW] == '0) ? '0 : 48'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg     <= {v_reg[5:1], s_valid};
            dv_reg    <= {dv_reg[NW-2:0], v_reg[6]};
            out_v_reg <= dv_reg[NW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dim1_reg  <= s_dimension;
            a1_reg[0] <= s_a_r0c0[EB-1:0];
            a1_reg[1] <= s_a_r0c1[EB-1:0];
            a1_reg[2] <= s_a_r0c2[EB-1:0];
            a1_reg[3] <= s_a_r1c0[EB-1:0];
            a1_reg[4] <= s_a_r1c1[EB-1:0];
            a1_reg[5] <= s_a_r1c2[EB-1:0];
            a1_reg[6] <= s_a_r2c0[EB-1:0];
            a1_reg[7] <= s_a_r2c1[EB-1:0];
            a1_reg[8] <= s_a_r2c2[EB-1:0];

            dim2_reg <= dim1_reg;
            for (int k = 0; k < 18; k++) begin
                p2_reg[k] <= smi_pkg::prod_t'(a1_reg[smi_pkg::PROD_A[k]])
                           * smi_pkg::prod_t'(a1_reg[smi_pkg::PROD_B[k]]);
            end
            a2_reg[0] <= a1_reg[4];
            a2_reg[1] <= a1_reg[1];
            a2_reg[2] <= a1_reg[3];
            for (int k = 0; k < 3; k++) r0_2_reg[k] <= a1_reg[k];

            dim3_reg <= dim2_reg;
            for (int k = 0; k < 9; k++) adj3_reg[k] <= adj_next[k];
            cof3_reg <= smi_pkg::adj_t'(p2_reg[16]) - smi_pkg::adj_t'(p2_reg[17]);
            for (int k = 0; k < 3; k++) a3_reg[k] <= r0_2_reg[k];

            dim4_reg  <= dim3_reg;
            a00_4_reg <= a3_reg[0];
            cof4_reg  <= cof3_reg;
            for (int k = 0; k < 9; k++) adj4_reg[k] <= adj3_reg[k];
            dp4_reg[0] <= smi_pkg::det_t'(a3_reg[0]) * smi_pkg::det_t'(adj3_reg[0]);
            dp4_reg[1] <= smi_pkg::det_t'(a3_reg[1]) * smi_pkg::det_t'(adj3_reg[3]);
            dp4_reg[2] <= smi_pkg::det_t'(a3_reg[2]) * smi_pkg::det_t'(adj3_reg[6]);

            for (int k = 0; k < 9; k++) adj5_reg[k] <= adj4_reg[k];
            det5_reg <= det_next;

            d_reg[0]   <= mag_d;
            det_reg[0] <= det5_reg;
            for (int k = 0; k < 9; k++) begin
                rem_reg[0][k] <= '0;
                nq_reg[0][k]  <= NW'(mag_a[k]) << FB;
                neg_reg[0][k] <= adj5_reg[k][AW-1] ^ det5_reg[DTW-1];
            end
            for (int s = 1; s <= NW; s++) begin
                d_reg[s]   <= d_reg[s-1];
                det_reg[s] <= det_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                for (int k = 0; k < 9; k++) begin
                    rem_reg[s][k] <= rem_next[s][k];
                    nq_reg[s][k]  <= nq_next[s][k];
                end
            end

            for (int k = 0; k < 9; k++) inv_reg[k] <= inv_next[k];
            deto_reg <= 49'(det_reg[NW]);
            sing_reg <= (det_reg[NW] == '0);
        end
    end

    assign m_inv_r0c0    = inv_reg[0];
    assign m_inv_r0c1    = inv_reg[1];
    assign m_inv_r0c2    = inv_reg[2];
    assign m_inv_r1c0    = inv_reg[3];
    assign m_inv_r1c1    = inv_reg[4];
    assign m_inv_r1c2    = inv_reg[5];
    assign m_inv_r2c0    = inv_reg[6];
    assign m_inv_r2c1    = inv_reg[7];
    assign m_inv_r2c2    = inv_reg[8];
    assign m_determinant = deto_reg;
    assign m_singular    = sing_reg;
endmodule
`default_nettype wire

/* design/smi_checker.sv */
// Port-level checker for the matrix inverse core, with its bind statement.
`default_nettype none
`include "small_matrix_inverse_core_macros.svh"
module smi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [47:0] m_inv_r0c0,
    input wire logic [47:0] m_inv_r1c1,
    input wire logic [47:0] m_inv_r2c2,
    input wire logic [48:0] m_determinant,
    input wire logic        m_singular
);
    `SMI_ASSERT_IMPL(sing_matches_det, aclk, aresetn, m_valid, m_singular == (m_determinant == 49'd0), "singular flag disagrees with determinant")
    `SMI_ASSERT_IMPL(sing_zero_inv, aclk, aresetn, m_valid && m_singular, m_inv_r0c0 == 48'd0 && m_inv_r1c1 == 48'd0 && m_inv_r2c2 == 48'd0, "singular word carries a nonzero inverse")
    `SMI_ASSERT_NEXT(stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_determinant), "stalled output word changed")
endmodule

bind small_matrix_inverse_core smi_checker u_smi_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_inv_r0c0(m_inv_r0c0), .m_inv_r1c1(m_inv_r1c1), .m_inv_r2c2(m_inv_r2c2),
    .m_determinant(m_determinant), .m_singular(m_singular)
);
`default_nettype wire
